/* design/wav_stream_parser_downmix_macros.svh */
// Assertion macros for the WAV stream parser.
// Included by the top level; no other dependencies.
`ifndef WAV_STREAM_PARSER_DOWNMIX_MACROS_SVH
`define WAV_STREAM_PARSER_DOWNMIX_MACROS_SVH
`ifndef SYNTHESIS
`define WSPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("wav parser assertion failed");
`define WSPD_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("wav parser forbidden condition");
`else
`define WSPD_ASSERT(lbl, clk, rstn, prop)
`define WSPD_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* design/wspd_pkg.sv */
// Types and constants for the WAV stream parser with stereo downmix.
// No dependencies.
package wspd_pkg;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_CID   = 4'd3,
        PH_CSIZE = 4'd4,
        PH_FMT   = 4'd5,
        PH_SKIP  = 4'd6,
        PH_PAD   = 4'd7,
        PH_LTYPE = 4'd8,
        PH_SID   = 4'd9,
        PH_SSIZE = 4'd10,
        PH_TEXT  = 4'd11,
        PH_SSKIP = 4'd12,
        PH_SPAD  = 4'd13,
        PH_DATA  = 4'd14,
        PH_HALT  = 4'd15
    } phase_t;

    typedef enum logic [2:0] {
        K_FORMAT    = 3'd0,
        K_TEXT_CHAR = 3'd1,
        K_TEXT_END  = 3'd2,
        K_SAMPLE    = 3'd3,
        K_END_SONG  = 3'd4,
        K_ERROR     = 3'd5
    } kind_t;

    localparam logic [1:0] ERR_NOT_WAVE   = 2'd0;
    localparam logic [1:0] ERR_NO_DATA    = 2'd1;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;

    localparam logic [1:0] TXT_ARTIST = 2'd0;
    localparam logic [1:0] TXT_ALBUM  = 2'd1;
    localparam logic [1:0] TXT_TITLE  = 2'd2;

    localparam logic [31:0] TAG_RIFF = 32'h52494646;
    localparam logic [31:0] TAG_WAVE = 32'h57415645;
    localparam logic [31:0] TAG_FMT  = 32'h666D7420;
    localparam logic [31:0] TAG_LIST = 32'h4C495354;
    localparam logic [31:0] TAG_INFO = 32'h494E464F;
    localparam logic [31:0] TAG_IART = 32'h49415254;
    localparam logic [31:0] TAG_INAM = 32'h494E414D;
    localparam logic [31:0] TAG_IPRD = 32'h49505244;
    localparam logic [31:0] TAG_DATA = 32'h64617461;

    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [15:0] FMT_EXTENSIBLE = 16'd65534;
    localparam logic [15:0] BITS_16        = 16'd16;
    localparam logic [15:0] STEREO         = 16'd2;

    typedef struct packed {
        logic        last;
        kind_t       kind;
        logic [1:0]  error_code;
        logic [15:0] sample;
        logic [7:0]  text_char;
        logic [1:0]  text_field;
        logic [15:0] sample_bits;
        logic [15:0] channels;
        logic [31:0] fmt_rate;
    } result_t;

endpackage

/* design/wav_stream_parser_downmix.sv */
// WAV stream parser top level: header/chunk walker, metadata and sample output.
// Depends on wspd_pkg and wav_stream_parser_downmix_macros.svh.
//
// Usage: feed the WAV file on the s_ channel, one byte per request in s_tdata,
// with s_tlast high on the final byte of the file. Results leave on the m_
// channel: m_tuser carries the result kind, m_tdata the payload fields and
// m_tlast marks the final result caused by one input byte.
// Each accepted byte is parsed in the cycle it is taken; its zero, one or two
// results are registered into a four-entry result queue, whose head drives
// m_tvalid, m_tdata, m_tuser and m_tlast.
// Throughput: one byte per cycle while the queue has room for two results.
// Bytes that yield one result at most (headers, skipped chunks, audio) thus
// flow at one per cycle when the receiver keeps up; the queue drain rate of one
// result per cycle is the limit when bytes give two results.
// When the receiver stalls, results wait in the queue and s_tready drops once
// fewer than two entries are free.
// Reset clears the parser to expect a new RIFF header and empties the queue.
// A byte with s_tlast also returns the parser to that state after its results.
module wav_stream_parser_downmix #(
    parameter int TEXT_BUFFER_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] file_byte
    input  logic        s_tlast,   // end_of_file
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] fmt_rate, [47:32] channels, [63:48] sample_bits,
    // [65:64] text_field, [73:66] text_char, [89:74] sample, [91:90] error_code
    output logic [95:0] m_tdata,
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last
);
    import wspd_pkg::*;

    localparam int TCW = (TEXT_BUFFER_BYTES > 2) ? $clog2(TEXT_BUFFER_BYTES) : 1;
    localparam logic [TCW-1:0] TEXT_MAX = TCW'(TEXT_BUFFER_BYTES - 1);

    phase_t         phase_reg, phase_next;
    logic [31:0]    shift_reg, shift_next;
    logic [1:0]     fbc_reg, fbc_next;
    logic [31:0]    tag_reg, tag_next;
    logic [31:0]    clen_reg, clen_next;
    logic [31:0]    skip_reg, skip_next;
    logic [31:0]    lrem_reg, lrem_next;
    logic [15:0]    fmt_reg, fmt_next;
    logic [15:0]    chan_reg, chan_next;
    logic [31:0]    rate_reg, rate_next;
    logic [15:0]    width_reg, width_next;
    logic [1:0]     tsel_reg, tsel_next;
    logic [TCW-1:0] tcnt_reg, tcnt_next;
    logic [7:0]     lowb_reg, lowb_next;
    logic [1:0]     pair_reg, pair_next;
    logic [15:0]    left_reg, left_next;

    result_t        res [2];
    logic [1:0]     res_cnt;

    result_t        q_reg [4];
    logic [1:0]     wr_reg, rd_reg;
    logic [2:0]     count_reg, count_next;

    logic s_acc, m_acc;

    assign s_tready = (count_reg <= 3'd2);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = (count_reg != 3'd0);
    assign m_acc    = m_tvalid && m_tready;

    always_comb begin
        logic [7:0]  b;
        logic        tag_done;
        logic [31:0] tag_shift;
        logic [31:0] size_shift;
        logic [31:0] k;
        logic [31:0] skip_dec;
        logic [31:0] lrem_dec;
        logic [15:0] s16;
        logic [16:0] sum;
        logic [16:0] avg;
        logic        stereo;
        logic        is_text;
        result_t     r;

        b          = s_tdata;
        tag_done   = (fbc_reg == 2'd3);
        tag_shift  = {tag_reg[23:0], b};
        size_shift = {b, shift_reg[31:8]};
        k          = clen_reg - skip_reg;
        skip_dec   = (skip_reg != 32'd0) ? skip_reg - 32'd1 : 32'd0;
        lrem_dec   = (lrem_reg != 32'd0) ? lrem_reg - 32'd1 : 32'd0;
        s16        = {b, lowb_reg};
        sum        = {left_reg[15], left_reg} + {s16[15], s16};
        avg        = $signed(sum + {16'd0, sum[16] & sum[0]}) >>> 1;
        stereo     = (chan_reg == STEREO);
        is_text    = 1'b0;

        phase_next = phase_reg;
        shift_next = shift_reg;
        fbc_next   = fbc_reg;
        tag_next   = tag_reg;
        clen_next  = clen_reg;
        skip_next  = skip_reg;
        lrem_next  = lrem_reg;
        fmt_next   = fmt_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        width_next = width_reg;
        tsel_next  = tsel_reg;
        tcnt_next  = tcnt_reg;
        lowb_next  = lowb_reg;
        pair_next  = pair_reg;
        left_next  = left_reg;

        r       = '0;
        res[0]  = '0;
        res[1]  = '0;
        res_cnt = 2'd0;

        if (s_acc) begin
            unique case (phase_reg)
                PH_RIFF, PH_WAVE, PH_CID, PH_LTYPE, PH_SID: begin
                    tag_next = tag_shift;
                    fbc_next = fbc_reg + 2'd1;
                    if (phase_reg == PH_LTYPE || phase_reg == PH_SID) begin
                        lrem_next = lrem_dec;
                    end
                    if (tag_done) begin
                        case (phase_reg)
                            PH_RIFF: begin
                                if (tag_shift != TAG_RIFF) begin
                                    r = '0;
                                    r.kind = K_ERROR;
                                    r.error_code = ERR_NOT_WAVE;
                                    res[res_cnt[0]] = r;
                                    res_cnt = res_cnt + 2'd1;
                                    phase_next = PH_HALT;
                                end else begin
                                    phase_next = PH_RSIZE;
                                end
                            end
                            PH_WAVE: begin
                                if (tag_shift != TAG_WAVE) begin
                                    r = '0;
                                    r.kind = K_ERROR;
                                    r.error_code = ERR_NOT_WAVE;
                                    res[res_cnt[0]] = r;
                                    res_cnt = res_cnt + 2'd1;
                                    phase_next = PH_HALT;
                                end else begin
                                    phase_next = PH_CID;
                                end
                            end
                            PH_CID: phase_next = PH_CSIZE;
                            PH_SID: phase_next = PH_SSIZE;
                            default: begin
                                // list type word
                                if (tag_shift == TAG_INFO) begin
                                    phase_next = (lrem_dec != 32'd0) ? PH_SID : PH_CID;
                                end else begin
                                    skip_next = lrem_dec;
                                    if (lrem_dec != 32'd0) phase_next = PH_SKIP;
                                    else phase_next = clen_reg[0] ? PH_PAD : PH_CID;
                                end
                            end
                        endcase
                    end
                end
                PH_RSIZE: begin
                    shift_next = size_shift;
                    fbc_next   = fbc_reg + 2'd1;
                    if (tag_done) phase_next = PH_WAVE;
                end
                PH_CSIZE: begin
                    shift_next = size_shift;
                    fbc_next   = fbc_reg + 2'd1;
                    if (tag_done) begin
                        clen_next = size_shift;
                        if (tag_reg == TAG_FMT) begin
                            fmt_next   = '0;
                            chan_next  = '0;
                            rate_next  = '0;
                            width_next = '0;
                            skip_next  = size_shift;
                            phase_next = (size_shift != 32'd0) ? PH_FMT : PH_CID;
                        end else if (tag_reg == TAG_LIST) begin
                            lrem_next  = size_shift;
                            phase_next = PH_LTYPE;
                        end else if (tag_reg == TAG_DATA) begin
                            if ((fmt_reg == FMT_PCM || fmt_reg == FMT_EXTENSIBLE) &&
                                width_reg == BITS_16) begin
                                r = '0;
                                r.kind        = K_FORMAT;
                                r.fmt_rate    = rate_reg;
                                r.channels    = chan_reg;
                                r.sample_bits = width_reg;
                                res[res_cnt[0]] = r;
                                res_cnt = res_cnt + 2'd1;
                                pair_next  = 2'd0;
                                phase_next = PH_DATA;
                            end else begin
                                r = '0;
                                r.kind = K_ERROR;
                                r.error_code = ERR_UNSUPPORTED;
                                res[res_cnt[0]] = r;
                                res_cnt = res_cnt + 2'd1;
                                phase_next = PH_HALT;
                            end
                        end else begin
                            skip_next  = size_shift;
                            phase_next = (size_shift != 32'd0) ? PH_SKIP : PH_CID;
                        end
                    end
                end
                PH_FMT, PH_SKIP: begin
                    if (phase_reg == PH_FMT) begin
                        if (k < 32'd2) begin
                            if (k[0]) fmt_next[15:8] = fmt_reg[15:8] | b;
                            else fmt_next[7:0] = fmt_reg[7:0] | b;
                        end else if (k < 32'd4) begin
                            if (k[0]) chan_next[15:8] = chan_reg[15:8] | b;
                            else chan_next[7:0] = chan_reg[7:0] | b;
                        end else if (k < 32'd8) begin
                            case (k[1:0])
                                2'd0:    rate_next[7:0]   = rate_reg[7:0] | b;
                                2'd1:    rate_next[15:8]  = rate_reg[15:8] | b;
                                2'd2:    rate_next[23:16] = rate_reg[23:16] | b;
                                default: rate_next[31:24] = rate_reg[31:24] | b;
                            endcase
                        end else if (k == 32'd14) begin
                            width_next[7:0] = width_reg[7:0] | b;
                        end else if (k == 32'd15) begin
                            width_next[15:8] = width_reg[15:8] | b;
                        end
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0) phase_next = clen_reg[0] ? PH_PAD : PH_CID;
                end
                PH_PAD: phase_next = PH_CID;
                PH_SSIZE: begin
                    lrem_next  = lrem_dec;
                    shift_next = size_shift;
                    fbc_next   = fbc_reg + 2'd1;
                    if (tag_done) begin
                        clen_next = size_shift;
                        skip_next = size_shift;
                        if (tag_reg == TAG_IART) begin
                            tsel_next = TXT_ARTIST;
                            is_text   = 1'b1;
                        end else if (tag_reg == TAG_IPRD) begin
                            tsel_next = TXT_ALBUM;
                            is_text   = 1'b1;
                        end else if (tag_reg == TAG_INAM) begin
                            tsel_next = TXT_TITLE;
                            is_text   = 1'b1;
                        end
                        if (is_text) tcnt_next = '0;
                        if (size_shift == 32'd0) begin
                            if (is_text) begin
                                r = '0;
                                r.kind       = K_TEXT_END;
                                r.text_field = tsel_next;
                                res[res_cnt[0]] = r;
                                res_cnt = res_cnt + 2'd1;
                            end
                            // zero size is even: no pad
                            phase_next = (lrem_dec != 32'd0) ? PH_SID : PH_CID;
                        end else begin
                            phase_next = is_text ? PH_TEXT : PH_SSKIP;
                        end
                    end
                end
                PH_TEXT, PH_SSKIP: begin
                    lrem_next = lrem_dec;
                    if (phase_reg == PH_TEXT) begin
                        if (b == 8'd0) begin
                            tcnt_next = TEXT_MAX;
                        end else if (tcnt_reg < TEXT_MAX) begin
                            r = '0;
                            r.kind       = K_TEXT_CHAR;
                            r.text_field = tsel_reg;
                            r.text_char  = b;
                            res[res_cnt[0]] = r;
                            res_cnt = res_cnt + 2'd1;
                            tcnt_next = tcnt_reg + TCW'(1);
                        end
                    end
                    skip_next = skip_dec;
                    if (skip_dec == 32'd0) begin
                        if (phase_reg == PH_TEXT) begin
                            r = '0;
                            r.kind       = K_TEXT_END;
                            r.text_field = tsel_reg;
                            res[res_cnt[0]] = r;
                            res_cnt = res_cnt + 2'd1;
                        end
                        if (clen_reg[0]) phase_next = PH_SPAD;
                        else phase_next = (lrem_dec != 32'd0) ? PH_SID : PH_CID;
                    end
                end
                PH_SPAD: begin
                    lrem_next  = lrem_dec;
                    phase_next = (lrem_dec != 32'd0) ? PH_SID : PH_CID;
                end
                PH_DATA: begin
                    if (!pair_reg[0]) begin
                        lowb_next = b;
                    end else if (!stereo) begin
                        r = '0;
                        r.kind   = K_SAMPLE;
                        r.sample = s16;
                        res[res_cnt[0]] = r;
                        res_cnt = res_cnt + 2'd1;
                    end else if (pair_reg == 2'd1) begin
                        left_next = s16;
                    end else begin
                        r = '0;
                        r.kind   = K_SAMPLE;
                        r.sample = avg[15:0];
                        res[res_cnt[0]] = r;
                        res_cnt = res_cnt + 2'd1;
                    end
                    pair_next = (pair_reg + 2'd1) & (stereo ? 2'd3 : 2'd1);
                end
                default: begin
                    // halted: drop bytes until end of file
                end
            endcase

            if (s_tlast) begin
                if (phase_next == PH_DATA) begin
                    r = '0;
                    r.kind = K_END_SONG;
                    res[res_cnt[0]] = r;
                    res_cnt = res_cnt + 2'd1;
                end else if (phase_next != PH_HALT) begin
                    r = '0;
                    r.kind = K_ERROR;
                    r.error_code = (phase_next <= PH_WAVE) ? ERR_NOT_WAVE : ERR_NO_DATA;
                    res[0]  = r;
                    res_cnt = 2'd1;
                end
                phase_next = PH_RIFF;
                shift_next = '0;
                fbc_next   = '0;
                tag_next   = '0;
                clen_next  = '0;
                skip_next  = '0;
                lrem_next  = '0;
                fmt_next   = '0;
                chan_next  = '0;
                rate_next  = '0;
                width_next = '0;
                tsel_next  = '0;
                tcnt_next  = '0;
                lowb_next  = '0;
                pair_next  = '0;
                left_next  = '0;
            end

            if (res_cnt == 2'd2) res[1].last = 1'b1;
            else if (res_cnt == 2'd1) res[0].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_RIFF;
            shift_reg <= '0;
            fbc_reg   <= '0;
            tag_reg   <= '0;
            clen_reg  <= '0;
            skip_reg  <= '0;
            lrem_reg  <= '0;
            fmt_reg   <= '0;
            chan_reg  <= '0;
            rate_reg  <= '0;
            width_reg <= '0;
            tsel_reg  <= '0;
            tcnt_reg  <= '0;
            lowb_reg  <= '0;
            pair_reg  <= '0;
            left_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            fbc_reg   <= fbc_next;
            tag_reg   <= tag_next;
            clen_reg  <= clen_next;
            skip_reg  <= skip_next;
            lrem_reg  <= lrem_next;
            fmt_reg   <= fmt_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            width_reg <= width_next;
            tsel_reg  <= tsel_next;
            tcnt_reg  <= tcnt_next;
            lowb_reg  <= lowb_next;
            pair_reg  <= pair_next;
            left_reg  <= left_next;
        end
    end

    // result queue
    assign count_next = count_reg + {1'b0, res_cnt} - {2'b00, m_acc};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_reg + res_cnt;
            rd_reg    <= rd_reg + {1'b0, m_acc};
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_cnt != 2'd0) q_reg[wr_reg] <= res[0];
        if (res_cnt == 2'd2) q_reg[wr_reg + 2'd1] <= res[1];
    end

    assign m_tdata = {4'd0, q_reg[rd_reg].error_code, q_reg[rd_reg].sample,
                      q_reg[rd_reg].text_char, q_reg[rd_reg].text_field,
                      q_reg[rd_reg].sample_bits, q_reg[rd_reg].channels,
                      q_reg[rd_reg].fmt_rate};
    assign m_tuser = q_reg[rd_reg].kind;
    assign m_tlast = q_reg[rd_reg].last;

    `include "wav_stream_parser_downmix_macros.svh"

    `WSPD_NEVER(a_queue_overflow, aclk, aresetn, count_reg > 3'd4)
    `WSPD_ASSERT(a_eof_restarts, aclk, aresetn, (s_acc && s_tlast) |=> (phase_reg == PH_RIFF))
    `WSPD_NEVER(a_results_without_byte, aclk, aresetn, (res_cnt != 2'd0) && !s_acc)

endmodule

/* sim/tb_wav_stream_parser_downmix.sv */
// Self-checking testbench for wav_stream_parser_downmix: drives WAV byte streams,
// predicts every result and compares it field by field. Depends on wspd_pkg.
module tb_wav_stream_parser_downmix;
    timeunit 1ns;
    timeprecision 1ps;
    import wspd_pkg::*;

    localparam int TEXT_MAX    = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_GOAL   = 750;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    wav_stream_parser_downmix #(.TEXT_BUFFER_BYTES(TEXT_MAX)) dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------- parser shadow state ----------------
    phase_t      phase;
    logic [31:0] shift_reg;
    int          byte_cnt;
    logic [31:0] tag_reg;
    logic [31:0] chunk_len;
    logic [31:0] skip_cnt;
    logic [31:0] list_left;
    logic [15:0] fmt_code;
    logic [15:0] chan_cnt;
    logic [31:0] rate_reg;
    logic [15:0] bits_reg;
    logic [1:0]  text_sel;
    int          text_cnt;
    logic [7:0]  low_hold;
    logic [1:0]  pair_cnt;
    logic [15:0] left_sample;

    result_t     byte_results[2];
    int          n_results;
    result_t     expected_q[$];
    int          mismatches;
    int          cycles;

    function automatic void clear_parser();
        phase = PH_RIFF;
        shift_reg = '0; byte_cnt = 0; tag_reg = '0; chunk_len = '0;
        skip_cnt = '0; list_left = '0;
        fmt_code = '0; chan_cnt = '0; rate_reg = '0; bits_reg = '0;
        text_sel = '0; text_cnt = 0;
        low_hold = '0; pair_cnt = '0; left_sample = '0;
    endfunction

    function automatic void add_result(result_t r);
        if (n_results >= 2) n_results = 1;
        byte_results[n_results] = r;
        n_results++;
    endfunction

    function automatic result_t blank(kind_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic void flag_error(logic [1:0] code);
        result_t r;
        r = blank(K_ERROR);
        r.error_code = code;
        add_result(r);
        phase = PH_HALT;
    endfunction

    function automatic bit shift_tag(logic [7:0] b);
        tag_reg = {tag_reg[23:0], b};
        byte_cnt++;
        if (byte_cnt >= 4) begin
            byte_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit shift_size(logic [7:0] b);
        shift_reg = {b, shift_reg[31:8]};
        byte_cnt++;
        if (byte_cnt >= 4) begin
            byte_cnt = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void top_body_done();
        phase = chunk_len[0] ? PH_PAD : PH_CID;
    endfunction

    function automatic void list_next();
        phase = (list_left != 0) ? PH_SID : PH_CID;
    endfunction

    function automatic void sub_done();
        if (chunk_len[0]) phase = PH_SPAD;
        else list_next();
    endfunction

    function automatic void list_count();
        if (list_left != 0) list_left--;
    endfunction

    function automatic void text_done();
        result_t r;
        r = blank(K_TEXT_END);
        r.text_field = text_sel;
        add_result(r);
    endfunction

    function automatic void open_top_chunk();
        result_t r;
        chunk_len = shift_reg;
        if (tag_reg == TAG_FMT) begin
            fmt_code = '0; chan_cnt = '0; rate_reg = '0; bits_reg = '0;
            skip_cnt = chunk_len;
            phase = (chunk_len != 0) ? PH_FMT : PH_CID;
        end else if (tag_reg == TAG_LIST) begin
            list_left = chunk_len;
            phase = PH_LTYPE;
        end else if (tag_reg == TAG_DATA) begin
            if ((fmt_code == FMT_PCM || fmt_code == FMT_EXTENSIBLE) && bits_reg == BITS_16) begin
                r = blank(K_FORMAT);
                r.fmt_rate = rate_reg;
                r.channels = chan_cnt;
                r.sample_bits = bits_reg;
                add_result(r);
                pair_cnt = '0;
                phase = PH_DATA;
            end else begin
                flag_error(ERR_UNSUPPORTED);
            end
        end else begin
            skip_cnt = chunk_len;
            phase = (chunk_len != 0) ? PH_SKIP : PH_CID;
        end
    endfunction

    function automatic void open_sub_chunk();
        bit is_text;
        is_text = 1'b1;
        chunk_len = shift_reg;
        skip_cnt = shift_reg;
        if (tag_reg == TAG_IART) text_sel = TXT_ARTIST;
        else if (tag_reg == TAG_IPRD) text_sel = TXT_ALBUM;
        else if (tag_reg == TAG_INAM) text_sel = TXT_TITLE;
        else is_text = 1'b0;
        if (is_text) begin
            text_cnt = 0;
            if (chunk_len == 0) begin
                text_done();
                sub_done();
            end else phase = PH_TEXT;
        end else begin
            if (chunk_len == 0) sub_done();
            else phase = PH_SSKIP;
        end
    endfunction

    function automatic void audio_byte(logic [7:0] b);
        bit          stereo;
        logic [15:0] s;
        int          mix;
        result_t     r;
        stereo = (chan_cnt == STEREO);
        if (!pair_cnt[0]) begin
            low_hold = b;
        end else begin
            s = {b, low_hold};
            if (!stereo || pair_cnt == 2'd3) begin
                r = blank(K_SAMPLE);
                if (!stereo) r.sample = s;
                else begin
                    mix = (int'($signed(left_sample)) + int'($signed(s))) / 2;
                    r.sample = mix[15:0];
                end
                add_result(r);
            end else begin
                left_sample = s;
            end
        end
        pair_cnt = stereo ? pair_cnt + 2'd1 : {1'b0, ~pair_cnt[0]};
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        logic [31:0] k;
        result_t     r;
        case (phase)
            PH_RIFF: begin
                if (shift_tag(b)) begin
                    if (tag_reg != TAG_RIFF) flag_error(ERR_NOT_WAVE);
                    else phase = PH_RSIZE;
                end
            end
            PH_RSIZE: begin
                if (shift_size(b)) phase = PH_WAVE;
            end
            PH_WAVE: begin
                if (shift_tag(b)) begin
                    if (tag_reg != TAG_WAVE) flag_error(ERR_NOT_WAVE);
                    else phase = PH_CID;
                end
            end
            PH_CID: begin
                if (shift_tag(b)) phase = PH_CSIZE;
            end
            PH_CSIZE: begin
                if (shift_size(b)) open_top_chunk();
            end
            PH_FMT: begin
                k = chunk_len - skip_cnt;
                if (k < 2) fmt_code |= 16'(b) << (8 * k);
                else if (k < 4) chan_cnt |= 16'(b) << (8 * (k - 2));
                else if (k < 8) rate_reg |= 32'(b) << (8 * (k - 4));
                else if (k == 14 || k == 15) bits_reg |= 16'(b) << (8 * (k - 14));
                if (skip_cnt != 0) skip_cnt--;
                if (skip_cnt == 0) top_body_done();
            end
            PH_SKIP: begin
                if (skip_cnt != 0) skip_cnt--;
                if (skip_cnt == 0) top_body_done();
            end
            PH_PAD: phase = PH_CID;
            PH_LTYPE: begin
                list_count();
                if (shift_tag(b)) begin
                    if (tag_reg == TAG_INFO) list_next();
                    else begin
                        skip_cnt = list_left;
                        if (skip_cnt != 0) phase = PH_SKIP;
                        else top_body_done();
                    end
                end
            end
            PH_SID: begin
                list_count();
                if (shift_tag(b)) phase = PH_SSIZE;
            end
            PH_SSIZE: begin
                list_count();
                if (shift_size(b)) open_sub_chunk();
            end
            PH_TEXT: begin
                list_count();
                if (b == 0) text_cnt = TEXT_MAX - 1;
                else if (text_cnt < TEXT_MAX - 1) begin
                    r = blank(K_TEXT_CHAR);
                    r.text_field = text_sel;
                    r.text_char = b;
                    add_result(r);
                    text_cnt++;
                end
                if (skip_cnt != 0) skip_cnt--;
                if (skip_cnt == 0) begin
                    text_done();
                    sub_done();
                end
            end
            PH_SSKIP: begin
                list_count();
                if (skip_cnt != 0) skip_cnt--;
                if (skip_cnt == 0) sub_done();
            end
            PH_SPAD: begin
                list_count();
                list_next();
            end
            PH_DATA: audio_byte(b);
            default: ;
        endcase
    endfunction

    // Work out the results of one accepted byte and queue them.
    function automatic void predict_byte(logic [7:0] b, bit eof);
        result_t r;
        n_results = 0;
        if (phase != PH_HALT) parse_byte(b);
        if (eof) begin
            if (phase == PH_DATA) add_result(blank(K_END_SONG));
            else if (phase != PH_HALT) begin
                n_results = 0;
                r = blank(K_ERROR);
                r.error_code = (phase <= PH_WAVE) ? ERR_NOT_WAVE : ERR_NO_DATA;
                add_result(r);
            end
            clear_parser();
        end
        if (n_results > 0) byte_results[n_results - 1].last = 1'b1;
        for (int i = 0; i < n_results; i++) expected_q.push_back(byte_results[i]);
    endfunction

    function automatic void note_mismatch(string what, result_t exp_r, result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", what, exp_r, got);
    endfunction

    // ---------------- result side ----------------
    initial m_tready = 1'b0;

    int ready_run, stall_run;
    always @(posedge aclk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
            m_tready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run <= ready_run - 1;
            m_tready <= 1'b1;
        end else begin
            ready_run <= $urandom_range(0, 2) == 0 ? $urandom_range(20, 80) : $urandom_range(0, 4);
            stall_run <= $urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        result_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.fmt_rate = m_tdata[31:0];
            got.channels = m_tdata[47:32];
            got.sample_bits = m_tdata[63:48];
            got.text_field = m_tdata[65:64];
            got.text_char = m_tdata[73:66];
            got.sample = m_tdata[89:74];
            got.error_code = m_tdata[91:90];
            got.kind = kind_t'(m_tuser);
            got.last = m_tlast;
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected result", '0, got);
            end else begin
                exp_r = expected_q.pop_front();
                if (got !== exp_r) note_mismatch("field", exp_r, got);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------- input side ----------------
    int sent_bytes;

    task automatic send_byte(logic [7:0] b, bit eof);
        int gap;
        gap = $urandom_range(0, 3) == 0 ?
              ($urandom_range(0, 12) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 3)) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eof;
        do @(posedge aclk); while (!s_tready);
        predict_byte(b, eof);
        sent_bytes++;
    endtask

    logic [7:0] file_q[$];

    function automatic void put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--) file_q.push_back(t[8*i +: 8]);
    endfunction

    function automatic void put_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [31:0] pick_tag();
        case ($urandom_range(0, 3))
            0: return TAG_IART;
            1: return TAG_IPRD;
            2: return TAG_INAM;
            default: return $urandom();
        endcase
    endfunction

    function automatic void put_fmt();
        int len;
        logic [15:0] code, ch, bits;
        len = $urandom_range(0, 5) == 0 ? $urandom_range(0, 19) : 16;
        case ($urandom_range(0, 7))
            0: code = FMT_EXTENSIBLE;
            1: code = 16'($urandom());
            2: code = 16'hFFFF;
            default: code = FMT_PCM;
        endcase
        case ($urandom_range(0, 5))
            0: ch = 16'd1;
            1: ch = 16'($urandom());
            default: ch = STEREO;
        endcase
        bits = $urandom_range(0, 7) == 0 ? 16'($urandom()) : BITS_16;
        put_tag(TAG_FMT);
        put_le(len, 4);
        for (int k = 0; k < len; k++) begin
            if (k < 2) file_q.push_back(code[8*k +: 8]);
            else if (k < 4) file_q.push_back(ch[8*(k-2) +: 8]);
            else if (k == 14 || k == 15) file_q.push_back(bits[8*(k-14) +: 8]);
            else file_q.push_back(8'($urandom()));
        end
        if (len % 2) file_q.push_back(8'($urandom()));
    endfunction

    function automatic void put_list();
        logic [7:0] body[$];
        int subs, len, size_word;
        logic [31:0] t;
        body = {};
        subs = $urandom_range(0, 3);
        for (int s = 0; s < subs; s++) begin
            t = pick_tag();
            len = $urandom_range(0, 7) == 0 ? $urandom_range(60, 75) : $urandom_range(0, 9);
            for (int i = 3; i >= 0; i--) body.push_back(t[8*i +: 8]);
            for (int i = 0; i < 4; i++) body.push_back(8'(len >> (8 * i)));
            for (int i = 0; i < len; i++)
                body.push_back($urandom_range(0, 9) == 0 ? 8'h00 : 8'($urandom_range(1, 255)));
            if (len % 2) body.push_back(8'($urandom()));
        end
        size_word = body.size() + 4;
        if ($urandom_range(0, 7) == 0) size_word = $urandom_range(0, size_word);
        put_tag(TAG_LIST);
        put_le(size_word, 4);
        put_tag($urandom_range(0, 5) == 0 ? 32'($urandom()) : TAG_INFO);
        foreach (body[i]) file_q.push_back(body[i]);
    endfunction

    // Assemble one mostly well-formed file; a few are corrupted or cut short.
    function automatic void build_file();
        int len;
        file_q = {};
        put_tag($urandom_range(0, 19) == 0 ? 32'($urandom()) : TAG_RIFF);
        put_le($urandom(), 4);
        put_tag($urandom_range(0, 19) == 0 ? 32'($urandom()) : TAG_WAVE);
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(0, 5);
            put_tag($urandom());
            put_le(len, 4);
            repeat (len + len % 2) file_q.push_back(8'($urandom()));
        end
        if ($urandom_range(0, 9) != 0) put_fmt();
        if ($urandom_range(0, 1) == 0) put_list();
        put_tag(TAG_DATA);
        put_le($urandom(), 4);
        repeat ($urandom_range(0, 40)) file_q.push_back(8'($urandom()));
        if ($urandom_range(0, 9) == 0) file_q = file_q[0:$urandom_range(0, file_q.size() - 1)];
    endfunction

    task automatic send_file();
        foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    typedef struct {
        logic [7:0] b;
        bit         eof;
        bit         typed;
        logic [1:0] code;
    } row_t;

    row_t rows[$];

    function automatic void add_row(logic [7:0] b, bit eof, bit typed, logic [1:0] code);
        row_t r;
        r.b = b; r.eof = eof; r.typed = typed; r.code = code;
        rows.push_back(r);
    endfunction

    initial begin
        int before_n;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        mismatches = 0;
        cycles = 0;
        sent_bytes = 0;
        ready_run = 0;
        stall_run = 0;
        clear_parser();

        // bad magic, ignored tail; end inside header; end before data
        add_row("R", 0, 0, 0); add_row("I", 0, 0, 0); add_row("F", 0, 0, 0);
        add_row("X", 0, 1, ERR_NOT_WAVE); add_row(8'hFF, 1, 0, 0);
        add_row("R", 0, 0, 0); add_row("I", 0, 0, 0); add_row("F", 0, 0, 0);
        add_row("F", 1, 1, ERR_NOT_WAVE);
        add_row("R", 0, 0, 0); add_row("I", 0, 0, 0); add_row("F", 0, 0, 0);
        add_row("F", 0, 0, 0);
        add_row(8'h00, 0, 0, 0); add_row(8'hFF, 0, 0, 0);
        add_row(8'h55, 0, 0, 0); add_row(8'hAA, 0, 0, 0);
        add_row("W", 0, 0, 0); add_row("A", 0, 0, 0); add_row("V", 0, 0, 0);
        add_row("E", 0, 0, 0);
        add_row("J", 0, 0, 0); add_row("U", 0, 0, 0); add_row("N", 0, 0, 0);
        add_row("K", 1, 1, ERR_NO_DATA);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            before_n = expected_q.size();
            send_byte(rows[i].b, rows[i].eof);
            if (rows[i].typed && (expected_q.size() == before_n ||
                expected_q[$].kind != K_ERROR || expected_q[$].error_code != rows[i].code)) begin
                mismatches++;
                $display("mismatch: row %0d did not predict error %0d", i, rows[i].code);
            end
        end

        // extremes: full-scale stereo audio, maximal rate
        file_q = {};
        put_tag(TAG_RIFF); put_le(32'hFFFF_FFFF, 4); put_tag(TAG_WAVE);
        put_tag(TAG_FMT); put_le(16, 4);
        put_le(FMT_PCM, 2); put_le(STEREO, 2); put_le(32'hFFFF_FFFF, 4);
        put_le(0, 4); put_le(0, 2); put_le(BITS_16, 2);
        put_tag(TAG_DATA); put_le(0, 4);
        put_le(16'h8000, 2); put_le(16'h8000, 2); put_le(16'h7FFF, 2); put_le(16'h7FFF, 2);
        put_le(16'hFFFF, 2); put_le(16'h0002, 2); put_le(16'h8000, 2); put_le(16'h7FFF, 2);
        put_le(16'h1234, 2);
        send_file();

        // hold the sender until the queue has drained
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);

        while (sent_bytes < ITEM_GOAL) begin
            build_file();
            if ($urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                while (expected_q.size() != 0) @(posedge aclk);
            end
            send_file();
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
